// File: design/jcg_pkg.sv
// Shared types and constants for the joint capture gate.
// Used by the front end, the work queue, the back end and the top level.
package jcg_pkg;

  localparam int JOINTS_DEF = 6;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACC23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACC45 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JRK01 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_JRK23 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_JRK45 = 3'd7;

  typedef struct packed {
    logic [2:0]         joint;
    logic signed [31:0] cmd_pos;
    logic signed [31:0] cmd_vel;
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic               last;
  } jcg_in_t;

  typedef struct packed {
    logic [2:0]  joint_out;
    logic [30:0] brake_dist;
    logic        joint_reject;
    logic        gap_over;
    logic [5:0]  rej_bits;
    logic        reject;
    logic        last_out;
  } jcg_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0]  joint;
    logic        last;
    logic        jvalid;
    logic        gap;
    logic        rate_rej;
    logic [32:0] s;
    logic [32:0] dv;
    logic [31:0] a;
    logic [31:0] j;
    logic [30:0] tol;
  } jcg_work_t;

endpackage

// File: design/jcg_front.sv
// Front end: configuration registers, input acceptance and classification.
// Depends on jcg_pkg.
module jcg_front #(
  parameter int JOINTS = jcg_pkg::JOINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  jcg_pkg::jcg_in_t               in_data,
  output logic                           push,
  output jcg_pkg::jcg_work_t             push_data,
  input  logic                           full
);
  import jcg_pkg::*;

  logic [30:0] tol;
  logic [30:0] rate;
  logic [63:0] accel [3];
  logic [63:0] jerk [3];

  logic signed [32:0] pdiff, vdiff;
  logic [32:0] pabs, vabs;
  logic [31:0] cabs, sabs;
  logic [63:0] acc_row, jrk_row;
  logic        jvalid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol   <= '0;
      rate  <= '0;
      accel <= '{default: '0};
      jerk  <= '{default: '0};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOL:   tol      <= cfg_data[30:0];
        REG_RATE:  rate     <= cfg_data[30:0];
        REG_ACC01: accel[0] <= cfg_data;
        REG_ACC23: accel[1] <= cfg_data;
        REG_ACC45: accel[2] <= cfg_data;
        REG_JRK01: jerk[0]  <= cfg_data;
        REG_JRK23: jerk[1]  <= cfg_data;
        REG_JRK45: jerk[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pdiff = {in_data.cmd_pos[31], in_data.cmd_pos} - {in_data.start_pos[31], in_data.start_pos};
    vdiff = {in_data.start_vel[31], in_data.start_vel} - {in_data.cmd_vel[31], in_data.cmd_vel};
    pabs  = pdiff[32] ? 33'(-pdiff) : 33'(pdiff);
    vabs  = vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
    cabs  = in_data.cmd_vel[31] ? (~in_data.cmd_vel + 32'd1) : in_data.cmd_vel;
    sabs  = in_data.start_vel[31] ? (~in_data.start_vel + 32'd1) : in_data.start_vel;
    jvalid = ({29'd0, in_data.joint} < 32'(JOINTS)) && (in_data.joint < 3'd6);
    case (in_data.joint[2:1])
      2'd0: begin
        acc_row = accel[0];
        jrk_row = jerk[0];
      end
      2'd1: begin
        acc_row = accel[1];
        jrk_row = jerk[1];
      end
      2'd2: begin
        acc_row = accel[2];
        jrk_row = jerk[2];
      end
      default: begin
        acc_row = '0;
        jrk_row = '0;
      end
    endcase

    push_data.joint    = in_data.joint;
    push_data.last     = in_data.last;
    push_data.jvalid   = jvalid;
    push_data.gap      = pabs > {2'b00, tol};
    push_data.rate_rej = sabs > {1'b0, rate};
    push_data.s        = {1'b0, cabs} + {1'b0, sabs};
    push_data.dv       = vabs;
    push_data.a        = !jvalid ? 32'd0 : (in_data.joint[0] ? acc_row[63:32] : acc_row[31:0]);
    push_data.j        = !jvalid ? 32'd0 : (in_data.joint[0] ? jrk_row[63:32] : jrk_row[31:0]);
    push_data.tol      = tol;
  end

  assign in_ready = !full;
  assign push     = in_valid && in_ready;

endmodule

// File: design/jcg_queue.sv
// Two-entry queue between front and back ends.
// Depends on jcg_pkg.
module jcg_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jcg_pkg::jcg_work_t push_data,
  output logic               full,
  output logic               pop_valid,
  input  logic               pop,
  output jcg_pkg::jcg_work_t pop_data
);
  import jcg_pkg::*;

  jcg_work_t  slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  assign full      = count == 2'd2;
  assign pop_valid = count != 2'd0;
  assign pop_data  = slot[rd_ptr];

endmodule

// File: design/jcg_back.sv
// Back end: serial multiply, restoring divide and square root sequencer,
// flag accumulation and output register. Depends on jcg_pkg.
module jcg_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  jcg_pkg::jcg_work_t q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jcg_pkg::jcg_out_t  out_data
);
  import jcg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [2:0] P_DVJ = 3'd0;
  localparam logic [2:0] P_AA  = 3'd1;
  localparam logic [2:0] P_AJ  = 3'd2;
  localparam logic [2:0] P_SDV = 3'd3;
  localparam logic [2:0] P_PS  = 3'd4;
  localparam logic [2:0] P_NS  = 3'd5;

  localparam logic [31:0] CAP = 32'h8000_0000;

  logic [2:0]  st, ph;
  logic [6:0]  cnt;
  jcg_work_t   w;
  logic        tri_mode;
  // multiplier
  logic [98:0] acc, mx, prod;
  logic [32:0] my;
  logic [63:0] dvj, aa, aj;
  // divider
  logic [95:0] num, quo, qfinal;
  logic [64:0] rem, rem_sh;
  logic [63:0] den;
  logic        qbit;
  // square root
  logic [62:0] sq_v, sq_bit;
  logic [63:0] sq_res, sq_t;

  logic [31:0] travel;
  logic        gap_flag;
  logic [5:0]  mask_acc;
  logic        fin_fire;
  logic        jrej, gap_next;
  logic [5:0]  mask_next;
  logic [64:0] ab_sum;

  assign prod   = my[0] ? acc + mx : acc;
  assign rem_sh = {rem[63:0], num[95]};
  assign qbit   = rem_sh >= {1'b0, den};
  assign qfinal = {quo[94:0], qbit};
  assign sq_t   = sq_res + {1'b0, sq_bit};
  assign ab_sum = {1'b0, dvj} + {1'b0, aa};

  assign q_pop    = (st == S_IDLE) && q_valid;
  assign fin_fire = (st == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    jrej      = w.rate_rej || (travel > {1'b0, w.tol});
    gap_next  = gap_flag || w.gap;
    mask_next = mask_acc;
    if (w.jvalid && jrej) mask_next[w.joint] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      gap_flag  <= 1'b0;
      mask_acc  <= '0;
    end else begin
      if (fin_fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (q_valid) begin
            if (q_data.a == '0 || q_data.j == '0 || q_data.dv == '0) st <= S_FIN;
            else st <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt == 7'd32) begin
            case (ph)
              P_DVJ, P_AA, P_SDV, P_PS, P_NS: st <= (ph == P_PS || ph == P_NS) ? S_DIV : S_MUL;
              P_AJ: st <= S_MUL;
              default: st <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (cnt == 7'd95) begin
            if (tri_mode && qfinal < 96'h4000_0000_0000_0000) st <= S_SQRT;
            else st <= S_FIN;
          end
        end
        S_SQRT: if (cnt == 7'd31) st <= S_FIN;
        S_FIN: begin
          if (fin_fire) begin
            st        <= S_IDLE;
            gap_flag  <= w.last ? 1'b0 : gap_next;
            mask_acc  <= w.last ? 6'd0 : mask_next;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        w      <= q_data;
        travel <= '0;
        ph     <= P_DVJ;
        cnt    <= '0;
        acc    <= '0;
        mx     <= {66'd0, q_data.dv};
        my     <= {1'b0, q_data.j};
      end
      S_MUL: begin
        if (cnt != 7'd32) begin
          acc <= prod;
          mx  <= {mx[97:0], 1'b0};
          my  <= {1'b0, my[32:1]};
          cnt <= cnt + 7'd1;
        end else begin
          cnt <= '0;
          acc <= '0;
          case (ph)
            P_DVJ: begin
              dvj <= prod[63:0];
              mx  <= {67'd0, w.a};
              my  <= {1'b0, w.a};
              ph  <= P_AA;
            end
            P_AA: begin
              aa <= prod[63:0];
              mx <= {67'd0, w.a};
              my <= {1'b0, w.j};
              ph <= P_AJ;
            end
            P_AJ: begin
              aj       <= prod[63:0];
              tri_mode <= dvj < aa;
              if (dvj < aa) begin
                mx <= {66'd0, w.s};
                my <= w.dv;
                ph <= P_SDV;
              end else begin
                mx <= {34'd0, ab_sum};
                my <= w.s;
                ph <= P_NS;
              end
            end
            P_SDV: begin
              mx <= {33'd0, prod[65:0]};
              my <= w.s;
              ph <= P_PS;
            end
            P_PS: begin
              num <= {5'd0, prod[98:8]};
              den <= {32'd0, w.j};
              rem <= '0;
            end
            P_NS: begin
              num <= {2'd0, prod[98:5]};
              den <= aj;
              rem <= '0;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        rem <= qbit ? rem_sh - {1'b0, den} : rem_sh;
        quo <= qfinal;
        num <= {num[94:0], 1'b0};
        cnt <= (cnt == 7'd95) ? 7'd0 : cnt + 7'd1;
        if (cnt == 7'd95) begin
          if (tri_mode) begin
            travel <= CAP;
            sq_v   <= qfinal[62:0];
            sq_res <= '0;
            sq_bit <= 63'h4000_0000_0000_0000;
          end else begin
            travel <= (qfinal > {64'd0, CAP}) ? CAP : qfinal[31:0];
          end
        end
      end
      S_SQRT: begin
        if ({1'b0, sq_v} >= sq_t) begin
          sq_v   <= 63'({1'b0, sq_v} - sq_t);
          sq_res <= {1'b0, sq_res[63:1]} + {1'b0, sq_bit};
        end else begin
          sq_res <= {1'b0, sq_res[63:1]};
        end
        sq_bit <= {2'b00, sq_bit[62:2]};
        cnt    <= cnt + 7'd1;
        if (cnt == 7'd31) begin
          travel <= ({1'b0, sq_v} >= sq_t) ?
                    32'({1'b0, sq_res[63:1]} + {1'b0, sq_bit}) : sq_res[32:1];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_data.joint_out    <= w.joint;
      out_data.brake_dist   <= travel[31] ? 31'h7FFF_FFFF : travel[30:0];
      out_data.joint_reject <= jrej;
      out_data.gap_over     <= gap_next;
      out_data.rej_bits     <= mask_next;
      out_data.reject       <= gap_next || (mask_next != 6'd0);
      out_data.last_out     <= w.last;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fin_fire && w.last |=> gap_flag == 1'b0 && mask_acc == 6'd0)
    else $error("flags not cleared after last beat");

  a_reject_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.reject == (out_data.gap_over || out_data.rej_bits != 6'd0))
    else $error("reject disagrees with flags");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    st == S_DIV |-> den != 64'd0)
    else $error("divide by zero reached");

endmodule

// File: design/joint_capture_gate_top.sv
// Top level of the joint capture gate: front end, work queue and back end.
// Depends on jcg_pkg, jcg_front, jcg_queue and jcg_back.
//
// One beat per joint. The back end computes the shed travel with a serial
// shift-add multiplier, a 96-step restoring divider and a 32-step square root
// (the root only on the triangular S-curve branch), and it takes no new joint
// until the current one is done; it skips the arithmetic when a limit or the
// velocity change is zero. The front end classifies and
// queues up to two further joints meanwhile; results leave in input order
// through an output register. Flags accumulate until the beat marked last.
module joint_capture_gate_top #(
  parameter int JOINTS = jcg_pkg::JOINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  jcg_pkg::jcg_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output jcg_pkg::jcg_out_t             out_data
);
  import jcg_pkg::*;

  logic      push, full, q_valid, q_pop;
  jcg_work_t push_data, q_data;

  jcg_front #(.JOINTS(JOINTS)) u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_data, .push, .push_data, .full
  );

  jcg_queue u_queue (
    .clk, .rst, .push, .push_data, .full,
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_data)
  );

  jcg_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_data, .out_valid, .out_ready, .out_data
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for joint_capture_gate_top: queue-fed driver, monitor,
// in-bench model of the shed-travel gate. Depends on jcg_pkg and the RTL.
module testbench;
  import jcg_pkg::*;

  localparam int  LIMIT_CYCLES = 1_000_000;
  localparam int  HOLD_CYCLES  = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TOL;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  jcg_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  jcg_out_t out_data;

  joint_capture_gate_top dut (.*);

  always #5 clk = ~clk;

  // model copy of the block's registers and flags
  logic [30:0] tol_r, rate_r;
  logic [63:0] accel_r [3];
  logic [63:0] jerk_r [3];
  logic        gap_acc;
  logic [5:0]  mask_acc;

  jcg_in_t  joint_q [$];
  jcg_out_t gate_results [$];
  int       idle_pct = 0, stall_pct = 0;
  int       mismatches = 0;
  int       cycle_cnt = 0;
  int       hold_left = 0;
  logic     hold_go = 1'b0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // travel capped at 2^31
  function automatic logic [31:0] shed_len(logic [32:0] s, logic [32:0] dv,
                                           logic [31:0] a, logic [31:0] j);
    logic [255:0] sw, dw, aw, jw, num, q;
    if (a == 0 || j == 0 || dv == 0) return '0;
    sw = s; dw = dv; aw = a; jw = j;
    if (dw * jw < aw * aw) begin
      num = (sw * sw * dw) >> 8;
      q = num / jw;
      if (q >= (256'd1 << 62)) return 32'h8000_0000;
      return 32'(isqrt(q[63:0]));
    end
    num = ((dw * jw + aw * aw) * sw) >> 5;
    q = num / (aw * jw);
    if (q > 256'h8000_0000) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic jcg_out_t gate_predict(jcg_in_t it);
    jcg_out_t r;
    longint gap, cv, sv;
    logic [32:0] s, dv;
    logic [31:0] a, j, trav;
    logic jv, jrej;
    cv = it.cmd_vel;
    sv = it.start_vel;
    gap = longint'(it.cmd_pos) - longint'(it.start_pos);
    if (gap < 0) gap = -gap;
    if (gap > longint'(tol_r)) gap_acc = 1'b1;
    jv = it.joint < 3'd6;
    a = '0; j = '0;
    if (jv) begin
      a = it.joint[0] ? accel_r[it.joint >> 1][63:32] : accel_r[it.joint >> 1][31:0];
      j = it.joint[0] ? jerk_r[it.joint >> 1][63:32] : jerk_r[it.joint >> 1][31:0];
    end
    s  = 33'((cv < 0 ? -cv : cv) + (sv < 0 ? -sv : sv));
    dv = 33'((sv - cv) < 0 ? cv - sv : sv - cv);
    trav = shed_len(s, dv, a, j);
    jrej = ((sv < 0 ? -sv : sv) > longint'(rate_r)) || (trav > {1'b0, tol_r});
    if (jv && jrej) mask_acc[it.joint] = 1'b1;
    r.joint_out    = it.joint;
    r.brake_dist   = trav[31] ? 31'h7FFF_FFFF : trav[30:0];
    r.joint_reject = jrej;
    r.gap_over     = gap_acc;
    r.rej_bits     = mask_acc;
    r.reject       = gap_acc || (mask_acc != 0);
    r.last_out     = it.last;
    if (it.last) begin
      gap_acc = 1'b0;
      mask_acc = '0;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) gate_results.push_back(gate_predict(in_data));
      if (!in_valid || in_ready) begin
        if (joint_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= joint_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk) begin
    jcg_out_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      if (out_valid && out_ready) begin
        if (gate_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          exp_r = gate_results.pop_front();
          if (out_data.joint_out != exp_r.joint_out ||
              out_data.brake_dist != exp_r.brake_dist ||
              out_data.joint_reject != exp_r.joint_reject ||
              out_data.gap_over != exp_r.gap_over ||
              out_data.rej_bits != exp_r.rej_bits ||
              out_data.reject != exp_r.reject ||
              out_data.last_out != exp_r.last_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_r, out_data);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TOL:   tol_r  = val[30:0];
      REG_RATE:  rate_r = val[30:0];
      REG_ACC01: accel_r[0] = val;
      REG_ACC23: accel_r[1] = val;
      REG_ACC45: accel_r[2] = val;
      REG_JRK01: jerk_r[0] = val;
      REG_JRK23: jerk_r[1] = val;
      REG_JRK45: jerk_r[2] = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [63:0] tol, logic [63:0] rate, logic [63:0] acc,
                           logic [63:0] jrk, bit scramble);
    write_reg(REG_TOL, tol);
    write_reg(REG_RATE, rate);
    write_reg(REG_ACC01, scramble ? {$urandom, $urandom} : acc);
    write_reg(REG_ACC23, scramble ? {$urandom_range(1 << 20), $urandom} : acc);
    write_reg(REG_ACC45, acc);
    write_reg(REG_JRK01, scramble ? {$urandom, $urandom_range(1 << 16)} : jrk);
    write_reg(REG_JRK23, scramble ? {$urandom, $urandom} : jrk);
    write_reg(REG_JRK45, jrk);
  endtask

  task automatic drain();
    while (joint_q.size() != 0 || in_valid || gate_results.size() != 0 || hold_left != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
      2: return '0;
      3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(1 << 12)) - (1 << 11));
    endcase
  endfunction

  function automatic jcg_in_t rand_joint(logic [2:0] jn, logic lst);
    jcg_in_t it;
    it.joint = jn;
    it.cmd_pos = rand_word();
    it.start_pos = $urandom_range(1) ? it.cmd_pos + $signed($urandom_range(4000)) - 2000
                                     : rand_word();
    it.cmd_vel = rand_word();
    it.start_vel = $urandom_range(3) == 0 ? it.cmd_vel : rand_word();
    it.last = lst;
    return it;
  endfunction

  // mostly full six-joint evaluations, some stray or truncated ones
  task automatic queue_random(int n);
    int k, jn;
    k = 0;
    while (k < n) begin
      if ($urandom_range(9) < 8) begin
        for (jn = 0; jn < 6; jn++) joint_q.push_back(rand_joint(3'(jn), jn == 5));
        k += 6;
      end else begin
        joint_q.push_back(rand_joint(3'($urandom_range(7)), 1'($urandom_range(1))));
        k++;
      end
    end
  endtask

  task automatic queue_directed();
    jcg_in_t it;
    int jn;
    for (jn = 0; jn < 8; jn++) begin
      it = rand_joint(3'(jn), 1'b0);
      it.start_vel = it.cmd_vel + 32'd5000;
      joint_q.push_back(it);
    end
    it = '{3'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1};
    joint_q.push_back(it);
    it = '{3'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0};
    joint_q.push_back(it);
    it = '{3'd2, 32'd0, 32'd1000, 32'd0, 32'd1000, 1'b1};    // no velocity change
    joint_q.push_back(it);
    it = '{3'd3, 32'd5, 32'd0, 32'd5, 32'd0, 1'b0};
    joint_q.push_back(it);
    it = '{3'd4, 32'd0, -32'sd3000, 32'd2000, 32'd3000, 1'b0};
    joint_q.push_back(it);
    it = '{3'd6, 32'h8000_0000, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0};
    joint_q.push_back(it);
    it = '{3'd7, 32'd0, 32'd0, 32'd0, 32'hFFFF_0000, 1'b1};
    joint_q.push_back(it);
    it = '{3'd5, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1};
    joint_q.push_back(it);
  endtask

  initial begin
    tol_r = '0; rate_r = '0;
    for (int i = 0; i < 3; i++) begin
      accel_r[i] = '0;
      jerk_r[i] = '0;
    end
    gap_acc = 1'b0;
    mask_acc = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // phase: defaults, then a mid-range setup with zero accel on joints 0 and 2 and zero jerk on joints 1 and 3
    queue_directed();
    drain();
    write_all(64'd1000, 64'd1 << 24, {32'd65536, 32'd0}, {32'd0, 32'd4096}, 1'b0);
    write_reg(REG_ACC45, {32'd400000, 32'd20});
    write_reg(REG_JRK45, {32'd3, 32'd900000});
    queue_directed();
    drain();

    write_all(64'h7FFF_FFFF, 64'h7FFF_FFFF, '1, '1, 1'b0);
    idle_pct = 66; stall_pct = 0;
    queue_random(80);
    drain();

    write_all(64'd0, 64'd0, '0, '0, 1'b0);
    idle_pct = 0; stall_pct = 66;
    queue_random(60);
    drain();

    write_all(64'($urandom_range(1 << 22)), 64'($urandom), '0, '0, 1'b1);
    idle_pct = 20; stall_pct = 20;
    queue_random(90);
    drain();

    // receiver held off while the sender keeps offering
    write_all(64'($urandom_range(1 << 16)), 64'($urandom_range(1 << 26)), '0, '0, 1'b1);
    idle_pct = 0; stall_pct = 0;
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    queue_random(90);
    drain();

    write_all(64'($urandom), 64'($urandom), '0, '0, 1'b1);
    idle_pct = 66; stall_pct = 66;
    queue_random(90);
    drain();

    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
